FILE: rtl/core/mfqs_pkg.sv
// Shared types and constants for the multilevel feedback queue scheduler.
// No dependencies; imported by the top level, mfqs_ctrl and mfqs_dp.
package mfqs_pkg;

  localparam int unsigned NUM_PROCS = 16;
  localparam int unsigned PIDX_W    = $clog2(NUM_PROCS);
  localparam int unsigned MAX_CYC   = 8;
  localparam int unsigned NUM_SLOTS = 2 * MAX_CYC - 1;
  localparam int unsigned MEM_DEPTH = NUM_PROCS * NUM_SLOTS;
  localparam int unsigned MEM_AW    = $clog2(MEM_DEPTH);

  localparam logic [PIDX_W-1:0] LAST_PIDX = PIDX_W'(NUM_PROCS - 1);
  localparam logic [PIDX_W-1:0] LAST_SLOT = PIDX_W'(NUM_SLOTS - 1);

  // request codes
  localparam logic [1:0] REQ_HDR  = 2'd0;
  localparam logic [1:0] REQ_BST  = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  // register indexes
  localparam logic [1:0] REG_L0Q = 2'd0;
  localparam logic [1:0] REG_L1Q = 2'd1;
  localparam logic [1:0] REG_PC  = 2'd2;

  // record kinds
  localparam logic REC_SWITCH = 1'b0;
  localparam logic REC_FINISH = 1'b1;

  typedef enum logic [2:0] {
    PS_NONE  = 3'd0,
    PS_WAIT  = 3'd1,
    PS_READY = 3'd2,
    PS_RUN   = 3'd3,
    PS_SLEEP = 3'd4,
    PS_DONE  = 3'd5
  } proc_st_e;

  typedef enum logic [3:0] {
    OP_NONE, OP_LATCH, OP_HDR, OP_CLR, OP_BRD, OP_BWR, OP_ARR, OP_WAKE,
    OP_WLD, OP_PICK, OP_SCAN, OP_SEL, OP_ADV, OP_RLD, OP_EMIT1, OP_EMIT2
  } dp_op_e;

  typedef enum logic [15:0] {
    S_IDLE = 16'h0001,
    S_DEC  = 16'h0002,
    S_HDR  = 16'h0004,
    S_CLR  = 16'h0008,
    S_BRD  = 16'h0010,
    S_BWR  = 16'h0020,
    S_ARR  = 16'h0040,
    S_WAKE = 16'h0080,
    S_WLD  = 16'h0100,
    S_PICK = 16'h0200,
    S_SCAN = 16'h0400,
    S_SEL  = 16'h0800,
    S_ADV  = 16'h1000,
    S_RLD  = 16'h2000,
    S_OUT1 = 16'h4000,
    S_OUT2 = 16'h8000
  } ctrl_state_e;

  typedef struct packed {
    dp_op_e            op;
    logic [PIDX_W-1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic       hdr_ok;
    logic       bst_ok;
    logic       tick;
    logic       arr_pend;
    logic       wake_hit;
    logic       scan_req;
    logic       idle_rec;
    logic [1:0] rec_cnt;
  } dp_stat_t;

endpackage

FILE: rtl/core/multilevel_feedback_queue_scheduler_unit.sv
// Top level of the multilevel feedback queue scheduler: register port,
// sequencer and datapath. Depends on mfqs_pkg, mfqs_ctrl, mfqs_dp.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+--------------------------------------
//  request   | start_i / busy_o        | req_type_i .. burst_length_i
//  record    | out_valid_o (one cycle) | record_kind_o .. last_o
//  registers | psel/penable/pwrite     | paddr, pwdata, prdata (pready high)
//
// A header load clears its process's burst slots one by one; a burst load
// reads, then writes the burst memory. A tick runs an arrival pass over every
// process slot only while arrivals are pending, an I/O wake-up pass over every
// slot with an extra burst memory read per wake-up, a shortest-burst scan over
// every slot and a select step when level 2 is involved, then advance, reload
// and the records, or just an idle record. busy_o is high for the whole item;
// records cannot be held off. Reset clears tables and queues, not burst memory.
module multilevel_feedback_queue_scheduler_unit
  import mfqs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [1:0]  req_type_i,
  input  logic [4:0]  process_id_i,
  input  logic [15:0] arrival_time_i,
  input  logic [1:0]  initial_level_i,
  input  logic [3:0]  cycle_count_i,
  input  logic [3:0]  burst_index_i,
  input  logic [7:0]  burst_length_i,
  output logic        out_valid_o,
  output logic        record_kind_o,
  output logic [4:0]  shown_process_o,
  output logic [15:0] record_time_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] waiting_time_o,
  output logic        all_done_o,
  output logic        last_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [7:0] l0q_q, l1q_q;
  logic [4:0] pc_q;
  dp_cmd_t    cmd;
  dp_stat_t   stat;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      l0q_q <= 8'd2;
      l1q_q <= 8'd6;
      pc_q  <= 5'd1;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_L0Q: l0q_q <= pwdata[7:0];
        REG_L1Q: l1q_q <= pwdata[7:0];
        REG_PC:  pc_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    case (paddr[3:2])
      REG_L0Q: prdata = {24'd0, l0q_q};
      REG_L1Q: prdata = {24'd0, l1q_q};
      REG_PC:  prdata = {27'd0, pc_q};
      default: prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;

  mfqs_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  mfqs_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .req_type_i      (req_type_i),
    .process_id_i    (process_id_i),
    .arrival_time_i  (arrival_time_i),
    .initial_level_i (initial_level_i),
    .cycle_count_i   (cycle_count_i),
    .burst_index_i   (burst_index_i),
    .burst_length_i  (burst_length_i),
    .l0_quantum_i    (l0q_q),
    .l1_quantum_i    (l1q_q),
    .proc_count_i    (pc_q),
    .out_valid_o     (out_valid_o),
    .record_kind_o   (record_kind_o),
    .shown_process_o (shown_process_o),
    .record_time_o   (record_time_o),
    .turnaround_o    (turnaround_o),
    .waiting_time_o  (waiting_time_o),
    .all_done_o      (all_done_o),
    .last_o          (last_o)
  );

endmodule

FILE: rtl/core/mfqs_ctrl.sv
// Sequencer for the scheduler: one-hot state machine and slot counter.
// Depends on mfqs_pkg; drives mfqs_dp through dp_cmd_t, reads dp_stat_t.
module mfqs_ctrl
  import mfqs_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o
);

  ctrl_state_e       state_q, state_d;
  logic [PIDX_W-1:0] idx_q, idx_d;

  // next state and command
  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    cmd_o.op  = OP_NONE;
    cmd_o.idx = idx_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.op = OP_LATCH;
          state_d  = S_DEC;
        end
      end
      S_DEC: begin
        idx_d = '0;
        if (stat_i.hdr_ok) state_d = S_HDR;
        else if (stat_i.bst_ok) state_d = S_BRD;
        else if (stat_i.tick) state_d = stat_i.arr_pend ? S_ARR : S_WAKE;
        else state_d = S_IDLE;
      end
      S_HDR: begin
        cmd_o.op = OP_HDR;
        state_d  = S_CLR;
      end
      S_CLR: begin
        cmd_o.op = OP_CLR;
        if (idx_q == LAST_SLOT) state_d = S_IDLE;
        else idx_d = idx_q + 1'b1;
      end
      S_BRD: begin
        cmd_o.op = OP_BRD;
        state_d  = S_BWR;
      end
      S_BWR: begin
        cmd_o.op = OP_BWR;
        state_d  = S_IDLE;
      end
      S_ARR: begin
        cmd_o.op = OP_ARR;
        idx_d    = idx_q + 1'b1;
        if (idx_q == LAST_PIDX) state_d = S_WAKE;
      end
      S_WAKE: begin
        cmd_o.op = OP_WAKE;
        if (stat_i.wake_hit) state_d = S_WLD;
        else if (idx_q == LAST_PIDX) state_d = S_PICK;
        else idx_d = idx_q + 1'b1;
      end
      S_WLD: begin
        cmd_o.op = OP_WLD;
        if (idx_q == LAST_PIDX) begin
          state_d = S_PICK;
        end else begin
          idx_d   = idx_q + 1'b1;
          state_d = S_WAKE;
        end
      end
      S_PICK: begin
        cmd_o.op = OP_PICK;
        idx_d    = '0;
        if (stat_i.idle_rec) state_d = S_OUT1;
        else if (stat_i.scan_req) state_d = S_SCAN;
        else state_d = S_ADV;
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (idx_q == LAST_PIDX) state_d = S_SEL;
        else idx_d = idx_q + 1'b1;
      end
      S_SEL: begin
        cmd_o.op = OP_SEL;
        state_d  = S_ADV;
      end
      S_ADV: begin
        cmd_o.op = OP_ADV;
        state_d  = S_RLD;
      end
      S_RLD: begin
        cmd_o.op = OP_RLD;
        state_d  = (stat_i.rec_cnt == 2'd0) ? S_IDLE : S_OUT1;
      end
      S_OUT1: begin
        cmd_o.op = OP_EMIT1;
        state_d  = (stat_i.rec_cnt == 2'd2) ? S_OUT2 : S_IDLE;
      end
      S_OUT2: begin
        cmd_o.op = OP_EMIT2;
        state_d  = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

FILE: rtl/core/mfqs_dp.sv
// Scheduler datapath: process tables, burst memory, ready queues, records.
// Depends on mfqs_pkg; sequenced by mfqs_ctrl through dp_cmd_t.
module mfqs_dp
  import mfqs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  dp_cmd_t     cmd_i,
  output dp_stat_t    stat_o,
  input  logic [1:0]  req_type_i,
  input  logic [4:0]  process_id_i,
  input  logic [15:0] arrival_time_i,
  input  logic [1:0]  initial_level_i,
  input  logic [3:0]  cycle_count_i,
  input  logic [3:0]  burst_index_i,
  input  logic [7:0]  burst_length_i,
  input  logic [7:0]  l0_quantum_i,
  input  logic [7:0]  l1_quantum_i,
  input  logic [4:0]  proc_count_i,
  output logic        out_valid_o,
  output logic        record_kind_o,
  output logic [4:0]  shown_process_o,
  output logic [15:0] record_time_o,
  output logic [15:0] turnaround_o,
  output logic [15:0] waiting_time_o,
  output logic        all_done_o,
  output logic        last_o
);

  // burst memory (current slot of each process is cached in rem_q)
  logic [7:0]        mem [MEM_DEPTH];
  logic [7:0]        rdata_q;
  logic [MEM_AW-1:0] mem_addr;
  logic              mem_we;
  logic [7:0]        mem_wdata;

  // latched item
  logic [1:0]  req_q;
  logic [4:0]  pid_q;
  logic [15:0] arr_in_q;
  logic [1:0]  lvl_in_q;
  logic [3:0]  cyc_in_q;
  logic [3:0]  bidx_q;
  logic [7:0]  blen_q;

  // per-process tables
  proc_st_e    status_q [NUM_PROCS];
  logic [3:0]  pos_q    [NUM_PROCS];
  logic [1:0]  level_q  [NUM_PROCS];
  logic [15:0] arrival_q[NUM_PROCS];
  logic [3:0]  cyc_q    [NUM_PROCS];
  logic [11:0] total_q  [NUM_PROCS];
  logic [7:0]  rem_q    [NUM_PROCS];
  logic [NUM_PROCS-1:0] srtn_q, sleep_q;

  // ready queues: 0 level 0, 1 level 1, 2 level 3
  logic [PIDX_W-1:0] fifo_q [3][NUM_PROCS];
  logic [PIDX_W-1:0] head_q [3];
  logic [PIDX_W:0]   cnt_q  [3];

  // run state
  logic              run_v_q;
  logic [PIDX_W-1:0] run_idx_q;
  logic [1:0]        run_lvl_q;
  logic [8:0]        quant_q;
  logic [15:0]       time_q;
  logic [4:0]        prev_q;
  logic              prev_v_q;
  logic              pend_q;
  logic              more_q;

  // shortest-burst scan
  logic              found_q, bounded_q;
  logic [7:0]        best_q;
  logic [PIDX_W-1:0] bsel_q;

  // reload after a burst ends
  logic              rld_q;
  logic [PIDX_W-1:0] ld_idx_q;

  // record buffer
  logic        rec_kind_q  [2];
  logic [4:0]  rec_shown_q [2];
  logic [15:0] rec_time_q  [2];
  logic [15:0] rec_ta_q    [2];
  logic [15:0] rec_wt_q    [2];
  logic [1:0]  rec_cnt_q;

  // combinational helpers
  logic [PIDX_W-1:0] pidx, ix, cur, row;
  logic [3:0]        slot;
  logic              pid_ok;
  proc_st_e          s_p;
  logic [4:0]        n_eff;
  logic              arr_hit, arr_match, wake_hit, take;
  logic [1:0]        wake_lvl;
  logic              q0_ne, q1_ne, q3_ne, idle_rec, scan_req, idle_all;
  logic [8:0]        q_dec;
  logic [7:0]        rem_cur, rem_n;
  logic [4:0]        newpos, lastpos, run_shown;
  logic              fin, slp, dem, sw_rec, rec_sel, emit_sel;
  logic [15:0]       time_n, ta, wt;
  logic              enq_en;
  logic [PIDX_W-1:0] enq_p;
  logic [1:0]        enq_lvl;

  always_comb begin
    pidx     = pid_q[PIDX_W-1:0] - 1'b1;
    pid_ok   = (pid_q != 5'd0) && (pid_q <= 5'(NUM_PROCS));
    s_p      = status_q[pidx];
    ix       = cmd_i.idx;
    cur      = run_idx_q;
    n_eff    = (proc_count_i > 5'(NUM_PROCS)) ? 5'(NUM_PROCS) : proc_count_i;

    arr_hit   = ({1'b0, ix} < n_eff) && (status_q[ix] == PS_WAIT);
    arr_match = (arrival_q[ix] == time_q);
    wake_hit  = sleep_q[ix] && (rem_q[ix] == 8'd0);
    wake_lvl  = (level_q[ix] != 2'd0) ? level_q[ix] - 2'd1 : 2'd0;
    take      = srtn_q[ix] && ((!found_q && !bounded_q) || (rem_q[ix] < best_q));

    q0_ne    = (cnt_q[0] != '0);
    q1_ne    = (cnt_q[1] != '0);
    q3_ne    = (cnt_q[2] != '0);
    idle_rec = !run_v_q && !q0_ne && !q1_ne && (srtn_q == '0) && !q3_ne &&
               !pend_q && (sleep_q == '0);
    scan_req = (srtn_q != '0) &&
               (run_v_q ? (run_lvl_q == 2'd2) : (!q0_ne && !q1_ne));

    // end-of-tick bookkeeping for the running process
    q_dec     = (run_v_q && (run_lvl_q < 2'd2) && (quant_q != 9'd0)) ?
                quant_q - 9'd1 : quant_q;
    rem_cur   = rem_q[cur];
    rem_n     = (rem_cur != 8'd0) ? rem_cur - 8'd1 : 8'd0;
    newpos    = {1'b0, pos_q[cur]} + 5'd1;
    lastpos   = {cyc_q[cur], 1'b0} - 5'd1;
    fin       = run_v_q && (rem_n == 8'd0) && (newpos >= lastpos);
    slp       = run_v_q && (rem_n == 8'd0) && !(newpos >= lastpos);
    dem       = run_v_q && (rem_n != 8'd0) && (run_lvl_q < 2'd2) && (q_dec == 9'd0);
    run_shown = run_v_q ? ({1'b0, run_idx_q} + 5'd1) : 5'd0;
    sw_rec    = !prev_v_q || (prev_q != run_shown);
    rec_sel   = sw_rec;
    time_n    = time_q + 16'd1;
    ta        = time_n - arrival_q[cur];
    wt        = ta - {4'b0, total_q[cur]};

    // nothing ready, running, sleeping or waiting to arrive
    idle_all = 1'b1;
    for (int i = 0; i < NUM_PROCS; i++) begin
      if (status_q[i] == PS_READY || status_q[i] == PS_RUN || status_q[i] == PS_SLEEP)
        idle_all = 1'b0;
      if (status_q[i] == PS_WAIT && (5'(i) < n_eff)) idle_all = 1'b0;
    end

    // enqueue request, at most one per cycle
    enq_en  = 1'b0;
    enq_p   = ix;
    enq_lvl = level_q[ix];
    case (cmd_i.op)
      OP_ARR:  enq_en = arr_hit && arr_match;
      OP_WAKE: begin
        enq_en  = wake_hit;
        enq_lvl = wake_lvl;
      end
      OP_SEL: begin
        enq_en  = found_q && run_v_q;
        enq_p   = cur;
        enq_lvl = 2'd3;
      end
      OP_ADV: begin
        enq_en  = dem;
        enq_p   = cur;
        enq_lvl = run_lvl_q + 2'd1;
      end
      default: enq_en = 1'b0;
    endcase

    // memory address: row * slots + slot
    row  = cur;
    slot = pos_q[cur] + 4'd1;
    case (cmd_i.op)
      OP_CLR: begin
        row  = pidx;
        slot = ix;
      end
      OP_BRD, OP_BWR: begin
        row  = pidx;
        slot = bidx_q;
      end
      OP_WAKE: begin
        row  = ix;
        slot = pos_q[ix] + 4'd1;
      end
      default: row = cur;
    endcase
    mem_addr  = MEM_AW'({row, 4'b0} - {4'b0, row} + {4'b0, slot});
    mem_we    = (cmd_i.op == OP_CLR) || (cmd_i.op == OP_BWR);
    mem_wdata = (cmd_i.op == OP_CLR) ? 8'd0 : blen_q;
  end

  // burst memory port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_addr] <= mem_wdata;
    rdata_q <= mem[mem_addr];
  end

  // tables and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_q <= '0; pid_q <= '0; arr_in_q <= '0; lvl_in_q <= '0;
      cyc_in_q <= '0; bidx_q <= '0; blen_q <= '0;
      for (int i = 0; i < NUM_PROCS; i++) begin
        status_q[i]  <= PS_NONE;
        pos_q[i]     <= '0;
        level_q[i]   <= '0;
        arrival_q[i] <= '0;
        cyc_q[i]     <= '0;
        total_q[i]   <= '0;
        rem_q[i]     <= '0;
      end
      for (int f = 0; f < 3; f++) begin
        head_q[f] <= '0;
        cnt_q[f]  <= '0;
        for (int i = 0; i < NUM_PROCS; i++) fifo_q[f][i] <= '0;
      end
      srtn_q <= '0; sleep_q <= '0;
      run_v_q <= 1'b0; run_idx_q <= '0; run_lvl_q <= '0; quant_q <= '0;
      time_q <= '0; prev_q <= '0; prev_v_q <= 1'b0; pend_q <= 1'b1; more_q <= 1'b0;
      found_q <= 1'b0; bounded_q <= 1'b0; best_q <= '0; bsel_q <= '0;
      rld_q <= 1'b0; ld_idx_q <= '0; rec_cnt_q <= '0;
      for (int r = 0; r < 2; r++) begin
        rec_kind_q[r] <= REC_SWITCH; rec_shown_q[r] <= '0; rec_time_q[r] <= '0;
        rec_ta_q[r] <= '0; rec_wt_q[r] <= '0;
      end
    end else begin
      case (cmd_i.op)
        OP_LATCH: begin
          req_q    <= req_type_i;
          pid_q    <= process_id_i;
          arr_in_q <= arrival_time_i;
          lvl_in_q <= initial_level_i;
          cyc_in_q <= cycle_count_i;
          bidx_q   <= burst_index_i;
          blen_q   <= burst_length_i;
          more_q   <= 1'b0;
          rec_cnt_q <= '0;
          rld_q    <= 1'b0;
        end
        OP_HDR: begin
          arrival_q[pidx] <= arr_in_q;
          level_q[pidx]   <= lvl_in_q;
          cyc_q[pidx]     <= (cyc_in_q == 4'd0) ? 4'd1 :
                             (cyc_in_q > 4'(MAX_CYC)) ? 4'(MAX_CYC) : cyc_in_q;
          pos_q[pidx]     <= '0;
          total_q[pidx]   <= '0;
          rem_q[pidx]     <= '0;
          status_q[pidx]  <= PS_WAIT;
          pend_q          <= 1'b1;
        end
        OP_BWR: begin
          total_q[pidx] <= total_q[pidx] - {4'b0, rdata_q} + {4'b0, blen_q};
          if (bidx_q == pos_q[pidx]) rem_q[pidx] <= blen_q;
        end
        OP_ARR: begin
          if (arr_hit && !arr_match) more_q <= 1'b1;
          if (ix == LAST_PIDX) pend_q <= more_q || (arr_hit && !arr_match);
        end
        OP_WAKE: begin
          if (wake_hit) begin
            sleep_q[ix] <= 1'b0;
            pos_q[ix]   <= pos_q[ix] + 4'd1;
            level_q[ix] <= wake_lvl;
          end
        end
        OP_WLD: rem_q[ix] <= (pos_q[ix] < 4'(NUM_SLOTS)) ? rdata_q : 8'd0;
        OP_PICK: begin
          found_q   <= 1'b0;
          bounded_q <= run_v_q;
          best_q    <= run_v_q ? rem_cur : 8'd0;
          if (!run_v_q) begin
            if (q0_ne) begin
              head_q[0] <= head_q[0] + 1'b1;
              cnt_q[0]  <= cnt_q[0] - 1'b1;
              run_v_q   <= 1'b1;
              run_idx_q <= fifo_q[0][head_q[0]];
              run_lvl_q <= level_q[fifo_q[0][head_q[0]]];
              status_q[fifo_q[0][head_q[0]]] <= PS_RUN;
              quant_q   <= (l0_quantum_i == 8'd0) ? 9'd1 : {1'b0, l0_quantum_i};
            end else if (q1_ne) begin
              head_q[1] <= head_q[1] + 1'b1;
              cnt_q[1]  <= cnt_q[1] - 1'b1;
              run_v_q   <= 1'b1;
              run_idx_q <= fifo_q[1][head_q[1]];
              run_lvl_q <= level_q[fifo_q[1][head_q[1]]];
              status_q[fifo_q[1][head_q[1]]] <= PS_RUN;
              quant_q   <= (l1_quantum_i == 8'd0) ? 9'd1 : {1'b0, l1_quantum_i};
            end else if (srtn_q == '0 && q3_ne) begin
              head_q[2] <= head_q[2] + 1'b1;
              cnt_q[2]  <= cnt_q[2] - 1'b1;
              run_v_q   <= 1'b1;
              run_idx_q <= fifo_q[2][head_q[2]];
              run_lvl_q <= level_q[fifo_q[2][head_q[2]]];
              status_q[fifo_q[2][head_q[2]]] <= PS_RUN;
              quant_q   <= '0;
            end else if (idle_rec) begin
              rec_kind_q[0]  <= REC_SWITCH;
              rec_shown_q[0] <= '0;
              rec_time_q[0]  <= time_q;
              rec_ta_q[0]    <= '0;
              rec_wt_q[0]    <= '0;
              rec_cnt_q      <= 2'd1;
            end
          end
        end
        OP_SCAN: begin
          if (take) begin
            found_q <= 1'b1;
            best_q  <= rem_q[ix];
            bsel_q  <= ix;
          end
        end
        OP_SEL: begin
          if (found_q) begin
            srtn_q[bsel_q]   <= 1'b0;
            status_q[bsel_q] <= PS_RUN;
            run_idx_q        <= bsel_q;
            if (!run_v_q) begin
              run_v_q   <= 1'b1;
              run_lvl_q <= level_q[bsel_q];
              quant_q   <= '0;
            end else begin
              level_q[cur] <= 2'd3;
            end
          end
        end
        OP_ADV: begin
          time_q  <= time_n;
          quant_q <= q_dec;
          if (sw_rec) begin
            rec_kind_q[0]  <= REC_SWITCH;
            rec_shown_q[0] <= run_shown;
            rec_time_q[0]  <= time_q;
            rec_ta_q[0]    <= '0;
            rec_wt_q[0]    <= '0;
            prev_q         <= run_shown;
            prev_v_q       <= 1'b1;
          end
          for (int i = 0; i < NUM_PROCS; i++) begin
            if (sleep_q[i] && rem_q[i] != 8'd0) rem_q[i] <= rem_q[i] - 8'd1;
          end
          rec_cnt_q <= 2'(sw_rec) + 2'(fin);
          rld_q     <= slp;
          ld_idx_q  <= cur;
          if (run_v_q) begin
            rem_q[cur] <= rem_n;
            if (rem_n == 8'd0) begin
              pos_q[cur] <= newpos[3:0];
              run_v_q    <= 1'b0;
              if (fin) begin
                status_q[cur]         <= PS_DONE;
                rec_kind_q[rec_sel]   <= REC_FINISH;
                rec_shown_q[rec_sel]  <= {1'b0, cur} + 5'd1;
                rec_time_q[rec_sel]   <= time_n;
                rec_ta_q[rec_sel]     <= ta;
                rec_wt_q[rec_sel]     <= wt;
              end else begin
                status_q[cur] <= PS_SLEEP;
                sleep_q[cur]  <= 1'b1;
              end
            end else if (dem) begin
              level_q[cur] <= run_lvl_q + 2'd1;
              run_v_q      <= 1'b0;
            end
          end
        end
        OP_RLD: begin
          if (rld_q) rem_q[ld_idx_q] <= (pos_q[ld_idx_q] < 4'(NUM_SLOTS)) ? rdata_q : 8'd0;
        end
        default: ;
      endcase

      // queue insertion
      if (enq_en) begin
        status_q[enq_p] <= PS_READY;
        case (enq_lvl)
          2'd0: if (cnt_q[0] < 5'(NUM_PROCS)) begin
            fifo_q[0][head_q[0] + cnt_q[0][PIDX_W-1:0]] <= enq_p;
            cnt_q[0] <= cnt_q[0] + 1'b1;
          end
          2'd1: if (cnt_q[1] < 5'(NUM_PROCS)) begin
            fifo_q[1][head_q[1] + cnt_q[1][PIDX_W-1:0]] <= enq_p;
            cnt_q[1] <= cnt_q[1] + 1'b1;
          end
          2'd2: srtn_q[enq_p] <= 1'b1;
          default: if (cnt_q[2] < 5'(NUM_PROCS)) begin
            fifo_q[2][head_q[2] + cnt_q[2][PIDX_W-1:0]] <= enq_p;
            cnt_q[2] <= cnt_q[2] + 1'b1;
          end
        endcase
      end
    end
  end

  // status to the sequencer
  assign stat_o.hdr_ok   = (req_q == REQ_HDR) && pid_ok &&
                           !(s_p == PS_READY || s_p == PS_RUN || s_p == PS_SLEEP);
  assign stat_o.bst_ok   = (req_q == REQ_BST) && pid_ok && (s_p == PS_WAIT) &&
                           (bidx_q < 4'(NUM_SLOTS));
  assign stat_o.tick     = (req_q == REQ_TICK);
  assign stat_o.arr_pend = pend_q;
  assign stat_o.wake_hit = wake_hit;
  assign stat_o.scan_req = scan_req;
  assign stat_o.idle_rec = idle_rec;
  assign stat_o.rec_cnt  = rec_cnt_q;

  // record output
  assign emit_sel        = (cmd_i.op == OP_EMIT2);
  assign out_valid_o     = (cmd_i.op == OP_EMIT1) || emit_sel;
  assign record_kind_o   = rec_kind_q[emit_sel];
  assign shown_process_o = rec_shown_q[emit_sel];
  assign record_time_o   = rec_time_q[emit_sel];
  assign turnaround_o    = rec_ta_q[emit_sel];
  assign waiting_time_o  = rec_wt_q[emit_sel];
  assign all_done_o      = idle_all;
  assign last_o          = emit_sel || (rec_cnt_q == 2'd1);

endmodule

FILE: rtl/core/mfqs_checker.sv
// Port-level checks for the scheduler top level, attached by bind.
// Depends on multilevel_feedback_queue_scheduler_unit ports only.
module mfqs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start_i,
  input logic        busy_o,
  input logic        out_valid_o,
  input logic        record_kind_o,
  input logic [15:0] turnaround_o,
  input logic [15:0] waiting_time_o,
  input logic        last_o
);

  // records only appear while an item is in progress
  a_rec_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> busy_o) else $error("record outside item");

  // an accepted item makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accept did not raise busy");

  // a record that is not last is followed at once by another
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |=> out_valid_o) else $error("record sequence broken");

  // last record ends the item
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_o) |=> !out_valid_o && !busy_o) else $error("item ran on");

  // switch records carry no timing figures
  a_switch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !record_kind_o) |-> (turnaround_o == 16'd0 && waiting_time_o == 16'd0))
    else $error("switch record with times");

endmodule

bind multilevel_feedback_queue_scheduler_unit mfqs_checker u_mfqs_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .out_valid_o    (out_valid_o),
  .record_kind_o  (record_kind_o),
  .turnaround_o   (turnaround_o),
  .waiting_time_o (waiting_time_o),
  .last_o         (last_o)
);
